[rtl/core/rtpdf_pkg.sv]
// ----------------------------------------------------------------------------
// RTP packet deframer package
// Phase codes, byte role codes and the result record shared by the parser
// and the top level.
// ----------------------------------------------------------------------------
package rtpdf_pkg;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_FIXED   = 5'b00001,
        PH_CSRC    = 5'b00010,
        PH_EXT     = 5'b00100,
        PH_ASF     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // Byte role codes as seen on the output
    localparam logic [2:0] ROLE_FIXED   = 3'd0;
    localparam logic [2:0] ROLE_CSRC    = 3'd1;
    localparam logic [2:0] ROLE_EXT     = 3'd2;
    localparam logic [2:0] ROLE_ASF     = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;

    // Phase counter width and the index of the last fixed header byte
    localparam int unsigned CNT_W = 18;
    localparam logic [CNT_W-1:0] FIXED_LAST = 18'd11;

    // Reset value of the ASF payload type register
    localparam logic [6:0] ASF_TYPE_RESET = 7'h60;

    // One tagged byte
    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] byte_role;
        logic [6:0] payload_kind;
        logic       marker_bit;
        logic       packet_begin;
        logic       truncated;
        logic       end_of_buffer;
    } t_result;

endpackage

[rtl/core/rtpdf_parse.sv]
// ----------------------------------------------------------------------------
// RTP deframer byte parser
// Holds the per-packet parse state and tags one byte per accepted item.
// ----------------------------------------------------------------------------
module rtpdf_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic [6:0]           i_asf_type,
    output rtpdf_pkg::t_result   o_result
);

    rtpdf_pkg::t_phase                r_phase, n_phase;
    logic [rtpdf_pkg::CNT_W-1:0]      r_count, n_count;
    logic [31:0]                      r_word, n_word;
    logic [6:0]                       r_type, n_type;
    logic                             r_marker, n_marker;
    logic [3:0]                       r_sc, n_sc;
    logic                             r_has_ext, n_has_ext;
    logic [3:0]                       r_skip, n_skip;
    logic [23:0]                      r_left, n_left;
    logic                             r_to_end, n_to_end;

    logic [31:0]                      shifted;
    logic [rtpdf_pkg::CNT_W-1:0]      count_inc;
    logic                             count_lt4;
    logic [rtpdf_pkg::CNT_W:0]        csrc_lim;
    logic [rtpdf_pkg::CNT_W-1:0]      ext_lim;
    logic [rtpdf_pkg::CNT_W-1:0]      asf_lim;
    logic [1:0]                       flag_sum;
    logic                             body_asf;
    logic [2:0]                       role;
    logic                             pkt_begin;
    logic                             trunc;

    assign shifted   = {r_word[23:0], i_data_byte};
    assign count_inc = r_count + 18'd1;
    assign count_lt4 = (r_count[rtpdf_pkg::CNT_W-1:2] == '0);
    assign csrc_lim  = {13'd0, r_sc, 2'b00};
    // type is settled well before the headers end
    assign body_asf  = (r_type == i_asf_type);

    // Next-state logic: one byte per pass
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_word    = r_word;
        n_type    = r_type;
        n_marker  = r_marker;
        n_sc      = r_sc;
        n_has_ext = r_has_ext;
        n_skip    = r_skip;
        n_left    = r_left;
        n_to_end  = r_to_end;
        role      = rtpdf_pkg::ROLE_PAYLOAD;
        flag_sum  = 2'd0;
        ext_lim   = '0;
        asf_lim   = '0;
        pkt_begin = (r_phase == rtpdf_pkg::PH_FIXED) && (r_count == '0);

        unique case (r_phase)
            rtpdf_pkg::PH_FIXED: begin
                role = rtpdf_pkg::ROLE_FIXED;
                if (r_count == '0) begin
                    n_type    = 7'd0;
                    n_marker  = 1'b0;
                    n_sc      = i_data_byte[3:0];
                    n_has_ext = i_data_byte[4];
                end else if (r_count == 18'd1) begin
                    n_marker = i_data_byte[7];
                    n_type   = i_data_byte[6:0];
                end
                if (r_count >= rtpdf_pkg::FIXED_LAST) begin
                    n_count = '0;
                    if (n_sc != 4'd0) begin
                        n_phase = rtpdf_pkg::PH_CSRC;
                    end else if (n_has_ext) begin
                        n_phase = rtpdf_pkg::PH_EXT;
                    end else if (body_asf) begin
                        n_phase = rtpdf_pkg::PH_ASF;
                    end else begin
                        n_phase  = rtpdf_pkg::PH_PAYLOAD;
                        n_to_end = 1'b1;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            rtpdf_pkg::PH_CSRC: begin
                role = rtpdf_pkg::ROLE_CSRC;
                if ({1'b0, count_inc} >= csrc_lim) begin
                    n_count = '0;
                    if (r_has_ext) begin
                        n_phase = rtpdf_pkg::PH_EXT;
                    end else if (body_asf) begin
                        n_phase = rtpdf_pkg::PH_ASF;
                    end else begin
                        n_phase  = rtpdf_pkg::PH_PAYLOAD;
                        n_to_end = 1'b1;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            rtpdf_pkg::PH_EXT: begin
                role = rtpdf_pkg::ROLE_EXT;
                if (count_lt4) begin
                    n_word = shifted;
                end
                // extension length in words, plus the 4-byte extension header
                ext_lim = {n_word[15:0], 2'b11};
                if (r_count >= 18'd3 && r_count >= ext_lim) begin
                    n_count = '0;
                    if (body_asf) begin
                        n_phase = rtpdf_pkg::PH_ASF;
                    end else begin
                        n_phase  = rtpdf_pkg::PH_PAYLOAD;
                        n_to_end = 1'b1;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            rtpdf_pkg::PH_ASF: begin
                role = rtpdf_pkg::ROLE_ASF;
                if (count_lt4) begin
                    n_word = shifted;
                end
                // R, D and I flags each add one word
                if (r_count == 18'd3) begin
                    flag_sum = {1'b0, n_word[29]} + {1'b0, n_word[28]}
                             + {1'b0, n_word[27]};
                    n_skip   = {flag_sum, 2'b00};
                end
                asf_lim = 18'd3 + {14'd0, n_skip};
                if (r_count >= 18'd3 && r_count >= asf_lim) begin
                    n_count = '0;
                    if (n_word[30]) begin
                        n_to_end = 1'b0;
                        if (n_word[23:0] == 24'd0) begin
                            n_phase = rtpdf_pkg::PH_FIXED;
                        end else begin
                            n_left  = n_word[23:0];
                            n_phase = rtpdf_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        n_to_end = 1'b1;
                        n_phase  = rtpdf_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            default: begin
                // payload, and any stray code
                role = rtpdf_pkg::ROLE_PAYLOAD;
                if (!r_to_end) begin
                    if (r_left <= 24'd1) begin
                        n_left  = 24'd0;
                        n_phase = rtpdf_pkg::PH_FIXED;
                        n_count = '0;
                    end else begin
                        n_left = r_left - 24'd1;
                    end
                end
            end
        endcase

        // cut short unless on a packet boundary or inside a to-end payload
        trunc = i_last_byte
              && !((n_phase == rtpdf_pkg::PH_FIXED && n_count == '0)
                   || (n_phase == rtpdf_pkg::PH_PAYLOAD && n_to_end));

        o_result.byte_out      = i_data_byte;
        o_result.byte_role     = role;
        o_result.payload_kind  = n_type;
        o_result.marker_bit    = n_marker;
        o_result.packet_begin  = pkt_begin;
        o_result.truncated     = trunc;
        o_result.end_of_buffer = i_last_byte;

        // buffer end: back to a clean parse
        if (i_last_byte) begin
            n_phase   = rtpdf_pkg::PH_FIXED;
            n_count   = '0;
            n_word    = '0;
            n_type    = '0;
            n_marker  = 1'b0;
            n_sc      = '0;
            n_has_ext = 1'b0;
            n_skip    = '0;
            n_left    = '0;
            n_to_end  = 1'b0;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rtpdf_pkg::PH_FIXED;
            r_count   <= '0;
            r_word    <= '0;
            r_type    <= '0;
            r_marker  <= 1'b0;
            r_sc      <= '0;
            r_has_ext <= 1'b0;
            r_skip    <= '0;
            r_left    <= '0;
            r_to_end  <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_word    <= n_word;
            r_type    <= n_type;
            r_marker  <= n_marker;
            r_sc      <= n_sc;
            r_has_ext <= n_has_ext;
            r_skip    <= n_skip;
            r_left    <= n_left;
            r_to_end  <= n_to_end;
        end
    end

`ifndef SYNTHESIS
    // last byte always leaves the parser at a packet start
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_phase == rtpdf_pkg::PH_FIXED && r_count == '0)
        else $error("parse state not cleared after last byte");

    // a counted payload always has bytes left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == rtpdf_pkg::PH_PAYLOAD && !r_to_end |-> r_left != 24'd0)
        else $error("counted payload with zero length");

    // contributing source phase only with a non-zero count
    a_csrc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == rtpdf_pkg::PH_CSRC |-> r_sc != 4'd0)
        else $error("source phase with zero sources");
`endif

endmodule

[rtl/core/rtp_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// RTP packet deframer
// Tags each byte of a buffer of back-to-back RTP packets with its role and
// the packet's payload type and marker.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------------------
//   in       | i_in_valid   | o_in_stall   | i_data_byte, i_last_byte
//   out      | o_out_valid  | i_out_stall  | o_byte_out .. o_end_of_buffer
//   config   | i_cfg_wr_en  | -            | i_cfg_wr_data
//
// One byte per cycle sustained while the skid register is empty. The parse
// state steps in a single pass from input to the result register. A skid
// register behind the result register takes one more item while the output
// is stalled; input stall is raised only while the skid register is full.
// Synchronous reset clears parse and handshake state and loads the ASF
// payload type register with 96.
// ----------------------------------------------------------------------------
module rtp_packet_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_role,
    output logic [6:0] o_payload_kind,
    output logic       o_marker_bit,
    output logic       o_packet_begin,
    output logic       o_truncated,
    output logic       o_end_of_buffer,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data
);

    logic [6:0]          r_asf_type;
    rtpdf_pkg::t_result  result;
    rtpdf_pkg::t_result  r_out, r_skid;
    logic                r_out_valid, r_skid_valid;
    logic                in_acc;
    logic                out_take;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    // ASF payload type register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asf_type <= rtpdf_pkg::ASF_TYPE_RESET;
        end else if (i_cfg_wr_en) begin
            r_asf_type <= i_cfg_wr_data;
        end
    end

    rtpdf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_asf_type  (r_asf_type),
        .o_result    (result)
    );

    // Result register and skid item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_out.byte_out;
    assign o_byte_role     = r_out.byte_role;
    assign o_payload_kind  = r_out.payload_kind;
    assign o_marker_bit    = r_out.marker_bit;
    assign o_packet_begin  = r_out.packet_begin;
    assign o_truncated     = r_out.truncated;
    assign o_end_of_buffer = r_out.end_of_buffer;

`ifndef SYNTHESIS
    // skid item only behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item without result item");

    // truncation only flagged on the last byte
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_end_of_buffer)
        else $error("truncated set away from buffer end");

    // packet start is always a fixed header byte
    a_begin_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_begin |-> o_byte_role == rtpdf_pkg::ROLE_FIXED)
        else $error("packet start outside fixed header");
`endif

endmodule
